// ===== hdl/clfd_pkg.sv =====
// ----------------------------------------------------------------------------
// clfd_pkg
// Types, constants and the CRC-16/MODBUS byte update for the log frame
// deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package clfd_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [8:0] HDR_BYTES      = 9'd10;
  localparam logic [9:0] OVERHEAD_BYTES = 10'd12;
  localparam logic [8:0] POS_MAX        = 9'd511;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_CRC_ERR = 2'd2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [2:0] REG_SYNC0   = 3'd0;
  localparam logic [2:0] REG_SYNC1   = 3'd1;
  localparam logic [2:0] REG_VERSION = 3'd2;
  localparam logic [2:0] REG_MAX_SRC = 3'd3;
  localparam logic [2:0] REG_MAX_LVL = 3'd4;
  localparam logic [2:0] REG_MAX_LEN = 3'd5;

  localparam int unsigned DATA_W = 72;

  // fields from the lowest bit up: payload, status, source, level,
  // timestamp, length, zero padding
  typedef struct packed {
    logic [5:0]  pad;
    logic [7:0]  length;
    logic [31:0] timestamp;
    logic [7:0]  level;
    logic [7:0]  source;
    logic [1:0]  status;
    logic [7:0]  payload;
  } out_data_t;

  typedef struct packed {
    logic      kind;
    out_data_t data;
  } result_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc_in,
                                           input logic [7:0]  data_in);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data_in};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/crc16_log_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// crc16_log_frame_deframer_top
// Log frame deframer: header checks, CRC-16/MODBUS check, payload forwarding.
//
// Usage:
//   in_*  : one frame byte per transfer in in_tdata, in_tlast on the final byte.
//   out_* : out_tuser 0 = payload byte, 1 = end-of-frame status with the
//           decoded header fields in out_tdata.
//   cfg_* : APB register port, six 8-bit registers at byte addresses 0..20.
// Each byte is decoded in the cycle it is accepted; its result, if any, is
// registered on out_* or, while out_* is held, in the skid register. One byte
// per cycle is taken while in_tready is high. The CRC byte update is a single
// combinational stage. A two-entry output (result register plus skid register)
// decouples the sides; in_tready drops only when both entries hold undelivered
// results, and bytes keep flowing while an entry is free.
// Reset clears frame state, empties the output and loads register defaults.
// Write the registers only between frames; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_log_frame_deframer_top (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_tvalid,
  output logic                        in_tready,
  input  wire  [7:0]                  in_tdata,   // byte_value
  input  wire                         in_tlast,   // last_byte
  output logic                        out_tvalid,
  input  wire                         out_tready,
  // [7:0] payload_byte, [9:8] frame_status, [17:10] frame_source,
  // [25:18] frame_level, [57:26] frame_timestamp, [65:58] frame_payload_length,
  // [71:66] zero
  output logic [clfd_pkg::DATA_W-1:0] out_tdata,
  output logic                        out_tuser,  // result_kind
  input  wire                         cfg_psel,
  input  wire                         cfg_penable,
  input  wire                         cfg_pwrite,
  input  wire  [4:0]                  cfg_paddr,
  input  wire  [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  import clfd_pkg::*;

  // configuration
  logic [7:0] sync0_r, sync1_r, version_r, max_src_r, max_lvl_r, max_len_r;
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync0_r   <= 8'd170;
      sync1_r   <= 8'd85;
      version_r <= 8'd1;
      max_src_r <= 8'd3;
      max_lvl_r <= 8'd3;
      max_len_r <= 8'd128;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SYNC0:   sync0_r   <= cfg_pwdata[7:0];
        REG_SYNC1:   sync1_r   <= cfg_pwdata[7:0];
        REG_VERSION: version_r <= cfg_pwdata[7:0];
        REG_MAX_SRC: max_src_r <= cfg_pwdata[7:0];
        REG_MAX_LVL: max_lvl_r <= cfg_pwdata[7:0];
        REG_MAX_LEN: max_len_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SYNC0:   cfg_prdata = {24'd0, sync0_r};
      REG_SYNC1:   cfg_prdata = {24'd0, sync1_r};
      REG_VERSION: cfg_prdata = {24'd0, version_r};
      REG_MAX_SRC: cfg_prdata = {24'd0, max_src_r};
      REG_MAX_LVL: cfg_prdata = {24'd0, max_lvl_r};
      REG_MAX_LEN: cfg_prdata = {24'd0, max_len_r};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  // frame state
  logic [8:0]  pos_r,   pos_nxt;
  logic [15:0] crc_r,   crc_nxt;
  logic [7:0]  src_r,   src_nxt;
  logic [7:0]  lvl_r,   lvl_nxt;
  logic [31:0] ts_r,    ts_nxt;
  logic [7:0]  len_r,   len_nxt;
  logic [15:0] rcrc_r,  rcrc_nxt;
  logic        fault_r, fault_nxt;

  logic        in_acc;
  logic [8:0]  pay_end;
  logic [9:0]  flen;
  logic        is_payload;
  logic        has_result;
  logic [1:0]  status;
  result_t     res;

  assign in_acc  = in_tvalid & in_tready;
  assign pay_end = HDR_BYTES + {1'b0, len_r};
  assign flen    = {1'b0, pos_r} + 10'd1;

  always_comb begin
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    src_nxt    = src_r;
    lvl_nxt    = lvl_r;
    ts_nxt     = ts_r;
    len_nxt    = len_r;
    rcrc_nxt   = rcrc_r;
    fault_nxt  = fault_r;
    is_payload = 1'b0;

    priority if (pos_r == 9'd0) begin
      if (in_tdata != sync0_r) fault_nxt = 1'b1;
    end else if (pos_r == 9'd1) begin
      if (in_tdata != sync1_r) fault_nxt = 1'b1;
    end else if (pos_r < HDR_BYTES) begin
      crc_nxt = crc_step(crc_r, in_tdata);
      unique case (pos_r[3:0])
        4'd2: if (in_tdata != version_r) fault_nxt = 1'b1;
        4'd3: begin
          src_nxt = in_tdata;
          if (in_tdata > max_src_r) fault_nxt = 1'b1;
        end
        4'd4: begin
          lvl_nxt = in_tdata;
          if (in_tdata > max_lvl_r) fault_nxt = 1'b1;
        end
        4'd5: ts_nxt[7:0]   = in_tdata;
        4'd6: ts_nxt[15:8]  = in_tdata;
        4'd7: ts_nxt[23:16] = in_tdata;
        4'd8: ts_nxt[31:24] = in_tdata;
        4'd9: begin
          len_nxt = in_tdata;
          if (in_tdata > max_len_r) fault_nxt = 1'b1;
        end
        default: ;
      endcase
    end else if (pos_r < pay_end) begin
      crc_nxt    = crc_step(crc_r, in_tdata);
      is_payload = 1'b1;
    end else if (pos_r == pay_end) begin
      rcrc_nxt[7:0] = in_tdata;
    end else if (pos_r == pay_end + 9'd1) begin
      rcrc_nxt[15:8] = in_tdata;
    end

    if (pos_r != POS_MAX) pos_nxt = pos_r + 9'd1;

    priority if (fault_nxt || (flen < OVERHEAD_BYTES) ||
                 (flen != OVERHEAD_BYTES + {2'b00, len_nxt})) begin
      status = STATUS_INVALID;
    end else if (rcrc_nxt != crc_nxt) begin
      status = STATUS_CRC_ERR;
    end else begin
      status = STATUS_OK;
    end

    res            = '0;
    has_result     = in_tlast | is_payload;
    if (in_tlast) begin
      res.kind           = KIND_STATUS;
      res.data.status    = status;
      res.data.source    = src_nxt;
      res.data.level     = lvl_nxt;
      res.data.timestamp = ts_nxt;
      res.data.length    = len_nxt;
    end else begin
      res.kind         = KIND_PAYLOAD;
      res.data.payload = in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 9'd0;
      crc_r   <= CRC_INIT;
      src_r   <= 8'd0;
      lvl_r   <= 8'd0;
      ts_r    <= 32'd0;
      len_r   <= 8'd0;
      rcrc_r  <= 16'd0;
      fault_r <= 1'b0;
    end else if (in_acc) begin
      if (in_tlast) begin
        pos_r   <= 9'd0;
        crc_r   <= CRC_INIT;
        src_r   <= 8'd0;
        lvl_r   <= 8'd0;
        ts_r    <= 32'd0;
        len_r   <= 8'd0;
        rcrc_r  <= 16'd0;
        fault_r <= 1'b0;
      end else begin
        pos_r   <= pos_nxt;
        crc_r   <= crc_nxt;
        src_r   <= src_nxt;
        lvl_r   <= lvl_nxt;
        ts_r    <= ts_nxt;
        len_r   <= len_nxt;
        rcrc_r  <= rcrc_nxt;
        fault_r <= fault_nxt;
      end
    end
  end

  // result register and skid register
  logic    out_vld_r, skid_vld_r;
  result_t out_r, skid_r;
  logic    push, pop;

  assign in_tready  = ~skid_vld_r;
  assign push       = in_acc & has_result;
  assign pop        = out_vld_r & out_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r.data;
  assign out_tuser  = out_r.kind;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_vld_r || pop) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (pop) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) out_r <= skid_r;
    end else if (push) begin
      if (!out_vld_r || pop) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held while result register empty");

  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_tlast && pos_r != POS_MAX) |=> (pos_r == $past(pos_r) + 9'd1))
    else $error("byte position did not advance");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (pos_r == 9'd0 && crc_r == CRC_INIT && !fault_r))
    else $error("frame state not cleared after last byte");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.kind == KIND_PAYLOAD) |->
      (out_r.data.status == STATUS_OK && out_r.data.length == 8'd0))
    else $error("payload result carries status fields");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the log frame deframer. Frames are built with
// random content, most of them well formed and the rest faulty, cut short,
// padded past the CRC or pure noise. They are streamed one byte per transfer
// with random input gaps and output back-pressure. An in-bench decoder
// predicts every payload and status transfer, and each one is compared field
// by field. The registers go through several settings, both extremes among
// them, and each write is read back.
// ----------------------------------------------------------------------------
module tb_top;
  import clfd_pkg::*;

  localparam int NUM_SETTINGS      = 6;
  localparam int BYTES_PER_SETTING = 115;
  localparam int OVERFLOW_BYTES    = 515;

  typedef enum int {
    FRM_GOOD, FRM_BAD_SYNC0, FRM_BAD_SYNC1, FRM_BAD_VERSION, FRM_BAD_SOURCE,
    FRM_BAD_LEVEL, FRM_BAD_LENGTH, FRM_BAD_CRC, FRM_TRUNCATED, FRM_TRAILING,
    FRM_NOISE
  } frame_kind_e;

  typedef struct packed {
    logic [7:0] value;
    logic       is_last;
  } frame_byte_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload;
    logic [1:0]  status;
    logic [7:0]  source;
    logic [7:0]  level;
    logic [31:0] timestamp;
    logic [7:0]  length;
  } frame_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = 8'd0;  // byte_value
  logic                in_tlast = 1'b0;  // last_byte
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // payload, status, source, level, timestamp, length, zero padding
  logic [DATA_W-1:0]   out_tdata;
  logic                out_tuser;        // result_kind
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [4:0]          cfg_paddr = 5'd0;
  logic [31:0]         cfg_pwdata = 32'd0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  crc16_log_frame_deframer_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // register copies
  logic [7:0]  reg_sync0   = 8'd170;
  logic [7:0]  reg_sync1   = 8'd85;
  logic [7:0]  reg_version = 8'd1;
  logic [7:0]  reg_max_src = 8'd3;
  logic [7:0]  reg_max_lvl = 8'd3;
  logic [7:0]  reg_max_len = 8'd128;

  // decoder state
  logic [8:0]  frame_pos = 9'd0;
  logic [15:0] crc_acc = CRC_INIT;
  logic [15:0] crc_rx = 16'd0;
  logic [7:0]  hdr_source = 8'd0;
  logic [7:0]  hdr_level = 8'd0;
  logic [7:0]  hdr_len = 8'd0;
  logic [31:0] hdr_ts = 32'd0;
  logic        hdr_bad = 1'b0;

  frame_byte_t   tx_bytes[$];
  frame_result_t due_results[$];
  logic [7:0]    frame_buf[$];
  frame_byte_t   next_byte;

  int  bytes_pushed = 0;
  int  bytes_taken = 0;
  int  mismatch_count = 0;
  int  n_ok = 0, n_invalid = 0, n_crc = 0, n_payload = 0;
  int  in_gap = 0;
  int  out_wait = 0;
  bit  in_gaps_on = 1'b1;
  bit  out_stalls_on = 1'b1;
  logic in_accepted = 1'b0;
  logic out_accepted = 1'b0;

  function automatic logic [15:0] modbus_crc_byte(input logic [15:0] acc,
                                                  input logic [7:0]  b);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = {1'b0, c[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic int draw_gap(input bit on);
    return on ? int'($urandom_range(0, 4)) : 0;
  endfunction

  task automatic deframe_byte(input logic [7:0] b, input logic is_last);
    logic [9:0]    p;
    logic [9:0]    pay_end;
    logic [9:0]    flen;
    logic          fwd;
    frame_result_t r;
    p       = {1'b0, frame_pos};
    pay_end = 10'(HDR_BYTES) + 10'(hdr_len);
    fwd     = 1'b0;
    r       = '0;
    if (p == 10'd0) begin
      if (b != reg_sync0) hdr_bad = 1'b1;
    end else if (p == 10'd1) begin
      if (b != reg_sync1) hdr_bad = 1'b1;
    end else if (p < 10'(HDR_BYTES)) begin
      crc_acc = modbus_crc_byte(crc_acc, b);
      case (p)
        10'd2: if (b != reg_version) hdr_bad = 1'b1;
        10'd3: begin
          hdr_source = b;
          if (b > reg_max_src) hdr_bad = 1'b1;
        end
        10'd4: begin
          hdr_level = b;
          if (b > reg_max_lvl) hdr_bad = 1'b1;
        end
        10'd9: begin
          hdr_len = b;
          if (b > reg_max_len) hdr_bad = 1'b1;
        end
        default: hdr_ts = hdr_ts | (32'(b) << (8 * (p - 10'd5)));
      endcase
    end else if (p < pay_end) begin
      crc_acc = modbus_crc_byte(crc_acc, b);
      fwd     = 1'b1;
    end else if (p == pay_end) begin
      crc_rx[7:0] = b;
    end else if (p == pay_end + 10'd1) begin
      crc_rx[15:8] = b;
    end

    if (frame_pos != POS_MAX) frame_pos = frame_pos + 9'd1;

    if (is_last) begin
      flen = p + 10'd1;
      r.kind = KIND_STATUS;
      if (hdr_bad || flen < OVERHEAD_BYTES || flen != OVERHEAD_BYTES + 10'(hdr_len)) begin
        r.status = STATUS_INVALID;
        n_invalid++;
      end else if (crc_rx != crc_acc) begin
        r.status = STATUS_CRC_ERR;
        n_crc++;
      end else begin
        r.status = STATUS_OK;
        n_ok++;
      end
      r.source    = hdr_source;
      r.level     = hdr_level;
      r.timestamp = hdr_ts;
      r.length    = hdr_len;
      due_results.push_back(r);
      frame_pos  = 9'd0;
      crc_acc    = CRC_INIT;
      crc_rx     = 16'd0;
      hdr_source = 8'd0;
      hdr_level  = 8'd0;
      hdr_len    = 8'd0;
      hdr_ts     = 32'd0;
      hdr_bad    = 1'b0;
    end else if (fwd) begin
      r.kind    = KIND_PAYLOAD;
      r.payload = b;
      due_results.push_back(r);
      n_payload++;
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // ---- driver: byte stream, changes at the falling edge
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_accepted)) begin
      if (in_accepted) in_gap = draw_gap(in_gaps_on);
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (tx_bytes.size() != 0) begin
        next_byte = tx_bytes.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= next_byte.value;
        in_tlast  <= next_byte.is_last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---- receiver back-pressure: hold off after each result transfer
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_accepted) out_wait = draw_gap(out_stalls_on);
      if (out_wait > 0) begin
        out_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---- monitor: check result transfers, then decode accepted bytes
  always @(posedge clk) begin : watch
    out_data_t     got;
    frame_result_t want;
    in_accepted  <= rst_n && in_tvalid && in_tready;
    out_accepted <= rst_n && out_tvalid && out_tready;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (due_results.size() == 0) begin
        $display("%0t: result transfer expected none got kind %0b data %0h",
                 $time, out_tuser, out_tdata);
        mismatch_count++;
      end else begin
        want = due_results.pop_front();
        compare_field("result_kind", want.kind, out_tuser);
        compare_field("payload_byte", want.payload, got.payload);
        compare_field("frame_status", want.status, got.status);
        compare_field("frame_source", want.source, got.source);
        compare_field("frame_level", want.level, got.level);
        compare_field("frame_timestamp", want.timestamp, got.timestamp);
        compare_field("frame_payload_length", want.length, got.length);
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      bytes_taken++;
      deframe_byte(in_tdata, in_tlast);
    end
  end

  // ---- frame construction
  task automatic build_good(input logic [7:0] src, input logic [7:0] lvl,
                            input logic [31:0] ts, input logic [7:0] plen);
    logic [15:0] crc;
    frame_buf.delete();
    frame_buf.push_back(reg_sync0);
    frame_buf.push_back(reg_sync1);
    frame_buf.push_back(reg_version);
    frame_buf.push_back(src);
    frame_buf.push_back(lvl);
    frame_buf.push_back(ts[7:0]);
    frame_buf.push_back(ts[15:8]);
    frame_buf.push_back(ts[23:16]);
    frame_buf.push_back(ts[31:24]);
    frame_buf.push_back(plen);
    repeat (plen) frame_buf.push_back(8'($urandom));
    crc = CRC_INIT;
    for (int i = 2; i < frame_buf.size(); i++) crc = modbus_crc_byte(crc, frame_buf[i]);
    frame_buf.push_back(crc[7:0]);
    frame_buf.push_back(crc[15:8]);
  endtask

  task automatic trim_frame(input int keep);
    while (frame_buf.size() > keep) void'(frame_buf.pop_back());
  endtask

  task automatic send_frame();
    frame_byte_t fbyte;
    for (int i = 0; i < frame_buf.size(); i++) begin
      fbyte.value   = frame_buf[i];
      fbyte.is_last = (i == frame_buf.size() - 1);
      tx_bytes.push_back(fbyte);
      bytes_pushed++;
    end
  endtask

  task automatic random_frame();
    frame_kind_e kind;
    logic [7:0]  src, lvl, plen;
    int          r, n, hi;
    r = $urandom_range(0, 99);
    kind = r < 55 ? FRM_GOOD :
           r < 60 ? FRM_BAD_SYNC0 :
           r < 63 ? FRM_BAD_SYNC1 :
           r < 66 ? FRM_BAD_VERSION :
           r < 71 ? FRM_BAD_SOURCE :
           r < 76 ? FRM_BAD_LEVEL :
           r < 80 ? FRM_BAD_LENGTH :
           r < 88 ? FRM_BAD_CRC :
           r < 93 ? FRM_TRUNCATED :
           r < 97 ? FRM_TRAILING : FRM_NOISE;
    src = 8'($urandom_range(0, reg_max_src));
    lvl = 8'($urandom_range(0, reg_max_lvl));
    if ($urandom_range(0, 19) == 0)
      plen = 8'($urandom_range(0, reg_max_len));
    else
      plen = 8'($urandom_range(0, reg_max_len < 8'd12 ? reg_max_len : 8'd12));
    if (kind == FRM_BAD_SOURCE && reg_max_src != 8'hFF)
      src = 8'($urandom_range(reg_max_src + 1, 255));
    if (kind == FRM_BAD_LEVEL && reg_max_lvl != 8'hFF)
      lvl = 8'($urandom_range(reg_max_lvl + 1, 255));
    if (kind == FRM_BAD_LENGTH && reg_max_len != 8'hFF) begin
      hi   = (reg_max_len + 6 > 255) ? 255 : reg_max_len + 6;
      plen = 8'($urandom_range(reg_max_len + 1, hi));
    end
    build_good(src, lvl, 32'($urandom), plen);
    case (kind)
      FRM_BAD_SYNC0:   frame_buf[0] = frame_buf[0] ^ 8'($urandom_range(1, 255));
      FRM_BAD_SYNC1:   frame_buf[1] = frame_buf[1] ^ 8'($urandom_range(1, 255));
      FRM_BAD_VERSION: frame_buf[2] = frame_buf[2] ^ 8'($urandom_range(1, 255));
      FRM_BAD_CRC: begin
        n = $urandom_range(10, frame_buf.size() - 1);
        frame_buf[n] = frame_buf[n] ^ 8'($urandom_range(1, 255));
      end
      FRM_TRUNCATED: trim_frame($urandom_range(1, frame_buf.size() - 1));
      FRM_TRAILING:  repeat ($urandom_range(1, 4)) frame_buf.push_back(8'($urandom));
      FRM_NOISE: begin
        frame_buf.delete();
        repeat ($urandom_range(1, 24)) frame_buf.push_back(8'($urandom));
      end
      default: ;
    endcase
    send_frame();
  endtask

  // ---- register port
  task automatic apb_cycle(input logic wr, input logic [2:0] idx,
                           input logic [7:0] wval, output logic [7:0] rval);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {24'd0, wval};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rval = cfg_prdata[7:0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    logic [7:0] rd;
    apb_cycle(1'b1, idx, val, rd);
    case (idx)
      REG_SYNC0:   reg_sync0   = val;
      REG_SYNC1:   reg_sync1   = val;
      REG_VERSION: reg_version = val;
      REG_MAX_SRC: reg_max_src = val;
      REG_MAX_LVL: reg_max_lvl = val;
      REG_MAX_LEN: reg_max_len = val;
      default: ;
    endcase
    apb_cycle(1'b0, idx, 8'd0, rd);
    if (rd !== val) begin
      $display("%0t: register %0d read back expected %0h got %0h", $time, idx, val, rd);
      mismatch_count++;
    end
  endtask

  task automatic apply_setting(input logic [7:0] s0, input logic [7:0] s1,
                               input logic [7:0] ver, input logic [7:0] msrc,
                               input logic [7:0] mlvl, input logic [7:0] mlen);
    write_reg(REG_SYNC0, s0);
    write_reg(REG_SYNC1, s1);
    write_reg(REG_VERSION, ver);
    write_reg(REG_MAX_SRC, msrc);
    write_reg(REG_MAX_LVL, mlvl);
    write_reg(REG_MAX_LEN, mlen);
  endtask

  task automatic wait_drained();
    while (bytes_taken != bytes_pushed || due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // ---- stimulus
  initial begin : stimulus
    int target;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      case (s)
        1: apply_setting(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        2: apply_setting(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        3, 4, 5: apply_setting(8'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom), 8'($urandom), 8'($urandom));
        default: ;
      endcase
      in_gaps_on    = (s != 1 && s != 3);
      out_stalls_on = (s != 1 && s != 2);
      @(posedge clk);
      if (s == 0) begin
        build_good(reg_max_src, 8'd0, 32'hFFFF_FFFF, 8'd0);
        send_frame();
        // end inside the payload
        build_good(8'd0, reg_max_lvl, 32'd0, 8'd2);
        trim_frame(11);
        send_frame();
        // end before the header is complete
        build_good(8'hFF, 8'hFF, 32'd0, 8'd0);
        trim_frame(3);
        send_frame();
      end
      if (s == 2) begin
        build_good(8'($urandom), 8'($urandom), 32'($urandom), 8'hFF);
        send_frame();
      end
      if (s == 3) begin
        // run the position counter into saturation
        build_good(reg_max_src, reg_max_lvl, 32'($urandom), 8'd0);
        while (frame_buf.size() < OVERFLOW_BYTES) frame_buf.push_back(8'($urandom));
        send_frame();
      end
      target = bytes_pushed + BYTES_PER_SETTING;
      while (bytes_pushed < target) random_frame();
      wait_drained();
    end
    repeat (8) @(negedge clk);
    if (due_results.size() != 0) begin
      $display("%0t: %0d results expected but never transferred", $time, due_results.size());
      mismatch_count++;
    end
    $display("Streamed %0d bytes under %0d register settings.", bytes_taken, NUM_SETTINGS);
    $display("Checked %0d frame statuses (%0d ok, %0d invalid, %0d CRC mismatch), %0d payload bytes.",
             n_ok + n_invalid + n_crc, n_ok, n_invalid, n_crc, n_payload);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d bytes and %0d results outstanding",
             bytes_pushed - bytes_taken, due_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
